// ===== sv/anti_replay_window_macros.svh =====
// ----------------------------------------------------------------------------
// anti_replay_window macros
// assertion helpers shared by the anti-replay window rtl
// ----------------------------------------------------------------------------
`ifndef ANTI_REPLAY_WINDOW_MACROS_SVH
`define ANTI_REPLAY_WINDOW_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ARW_ASSERT_SAME(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ARW_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/arw_pkg.sv =====
// ----------------------------------------------------------------------------
// arw_pkg
// types and constants of the anti-replay sliding window
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package arw_pkg;

    localparam int WINDOW_BITS_DEF = 128;
    localparam int SEQ_W           = 64;

    typedef enum logic [1:0] {
        CMD_CHECK  = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_ACCEPTED  = 2'd0,
        ST_INVALID   = 2'd1,
        ST_TOO_OLD   = 2'd2,
        ST_DUPLICATE = 2'd3
    } status_t;

endpackage

// ===== sv/anti_replay_window.sv =====
// an item passes the input register, then the result register
// one item per cycle while m_ready does not stall the result register; the window state updates
// in the same cycle an item moves from the input register to the result register
// reset: synchronous active-low aresetn empties the window (highest = 0, map = 0)
// and drops any item in flight
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anti_replay_window
// sliding-window replay check with a seen map below the highest sequence
// ----------------------------------------------------------------------------
`include "anti_replay_window_macros.svh"

module anti_replay_window
    import arw_pkg::*;
#(
    parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_cmd,
    input  logic [SEQ_W-1:0] s_seq,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_status
);

    localparam int SHW = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;

    // input register
    logic             in_valid_reg;
    logic [1:0]       cmd_reg;
    logic [SEQ_W-1:0] seq_reg;

    // window state
    logic [SEQ_W-1:0]       highest_reg, highest_next;
    logic [WINDOW_BITS-1:0] map_reg, map_next;

    // result register
    logic    out_valid_reg;
    status_t status_reg, status_next;

    logic             advance;
    logic             record;
    logic [SEQ_W-1:0] diff_up;
    logic [SEQ_W-1:0] diff_old;
    logic             seq_higher;
    logic             up_in_range;
    logic             old_in_window;
    logic [SHW-1:0]   old_idx;
    logic             bit_seen;
    logic [WINDOW_BITS-1:0] shifted_map;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_status = status_reg;

    assign diff_up       = seq_reg - highest_reg;
    assign diff_old      = highest_reg - seq_reg;
    assign seq_higher    = seq_reg > highest_reg;
    assign up_in_range   = diff_up < SEQ_W'(WINDOW_BITS);
    assign old_in_window = diff_old < SEQ_W'(WINDOW_BITS);
    assign old_idx       = diff_old[SHW-1:0];
    assign bit_seen      = old_in_window && map_reg[old_idx];
    assign shifted_map   = up_in_range ? (map_reg << diff_up[SHW-1:0]) : '0;

    always_comb begin
        highest_next = highest_reg;
        map_next     = map_reg;
        status_next  = ST_ACCEPTED;
        record       = 1'b0;
        case (cmd_t'(cmd_reg))
            CMD_CLEAR: begin
                highest_next = '0;
                map_next     = '0;
            end
            CMD_UPDATE: begin
                record = 1'b1;
            end
            default: begin
                record = 1'b0;
            end
        endcase
        if (cmd_t'(cmd_reg) != CMD_CLEAR) begin
            if (seq_reg == '0) begin
                status_next = ST_INVALID;
            end else if (highest_reg == '0) begin
                // empty window takes the first number as is
                if (record) begin
                    highest_next = seq_reg;
                    map_next     = WINDOW_BITS'(1);
                end
            end else if (seq_higher) begin
                if (record) begin
                    highest_next = seq_reg;
                    map_next     = shifted_map | WINDOW_BITS'(1);
                end
            end else if (!old_in_window) begin
                status_next = ST_TOO_OLD;
            end else if (bit_seen) begin
                status_next = ST_DUPLICATE;
            end else if (record) begin
                map_next = map_reg | (WINDOW_BITS'(1) << old_idx);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            highest_reg   <= '0;
            map_reg       <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                highest_reg   <= highest_next;
                map_reg       <= map_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= s_cmd;
            seq_reg <= s_seq;
        end
        if (advance) begin
            status_reg <= status_next;
        end
    end

    `ARW_ASSERT_NEXT(a_clear_empties, aclk, aresetn, advance && cmd_reg == CMD_CLEAR, highest_reg == '0 && map_reg == '0, "clear did not empty the window")
    `ARW_ASSERT_NEXT(a_highest_monotonic, aclk, aresetn, advance && cmd_reg != CMD_CLEAR, highest_reg >= $past(highest_reg), "highest sequence moved backward")
    `ARW_ASSERT_SAME(a_newest_marked, aclk, aresetn, highest_reg != '0, map_reg[0], "non-empty window lacks its newest mark")
    `ARW_ASSERT_NEXT(a_record_fills, aclk, aresetn, advance && cmd_reg == CMD_UPDATE && status_next == ST_ACCEPTED, highest_reg != '0, "recorded item left the window empty")

endmodule
